// File: hdl/ssmd_pkg.sv
package ssmd_pkg;

    // Display modes carried in the func field.
    typedef enum logic [1:0] {
        MODE_MIN_SEC   = 2'd0,
        MODE_SEC_ANIM  = 2'd1,
        MODE_MILLI_SEC = 2'd2
    } t_mode;

    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] milli_count;
        logic [31:0] second_count;
    } t_in;

    typedef struct packed {
        logic [7:0] digit_enable;
        logic [7:0] segment_bits;
    } t_out;

    localparam int unsigned SecMod   = 3600;
    localparam int unsigned MilliMod = 1000;

    localparam logic [7:0] SEG_BLANK   = 8'hFF;
    localparam logic [7:0] SEG_DP_MASK = 8'h7F;
    localparam logic [7:0] EN_FIRST    = 8'h80;
    localparam logic [7:0] EN_NONE     = 8'h00;

    // Reciprocals for the constant divisions of the reduced counts.
    localparam logic [12:0] RECIP_10  = 13'd6554;  // x/10  = (x*6554) >> 16
    localparam logic [12:0] RECIP_60  = 13'd4370;  // x/60  = (x*4370) >> 18
    localparam logic [10:0] RECIP_600 = 11'd1748;  // x/600 = (x*1748) >> 20
    localparam logic [12:0] RECIP_100 = 13'd5243;  // x/100 = (x*5243) >> 19

    // Residue of one byte of a count, weighted by its place, modulo 3600 or 1000.
    typedef logic [255:0][11:0] t_stab;
    typedef logic [255:0][9:0]  t_mtab;

    function automatic t_stab make_stab(input int unsigned k);
        t_stab      tab;
        longint unsigned v;
        for (int unsigned b = 0; b < 256; b++) begin
            v      = longint'(b) << (8 * k);
            tab[b] = 12'(v % SecMod);
        end
        return tab;
    endfunction

    function automatic t_mtab make_mtab(input int unsigned k);
        t_mtab      tab;
        longint unsigned v;
        for (int unsigned b = 0; b < 256; b++) begin
            v      = longint'(b) << (8 * k);
            tab[b] = 10'(v % MilliMod);
        end
        return tab;
    endfunction

    localparam t_stab S_TAB1 = make_stab(1);
    localparam t_stab S_TAB2 = make_stab(2);
    localparam t_stab S_TAB3 = make_stab(3);
    localparam t_mtab M_TAB1 = make_mtab(1);
    localparam t_mtab M_TAB2 = make_mtab(2);
    localparam t_mtab M_TAB3 = make_mtab(3);

    localparam logic [15:0][7:0] ANIM_A = {
        8'hF0, 8'hF4, 8'hF6, 8'hF7, 8'hF7, 8'hF7, 8'hF7, 8'hF7,
        8'hF0, 8'hF8, 8'hF8, 8'hF8, 8'hF8, 8'hF8, 8'hF9, 8'hFB
    };

    localparam logic [15:0][7:0] ANIM_B = {
        8'hC6, 8'hC6, 8'hC6, 8'hC6, 8'hC7, 8'hE7, 8'hF7, 8'hFF,
        8'hC6, 8'hC6, 8'hCE, 8'hDE, 8'hFE, 8'hFF, 8'hFF, 8'hFF
    };

    function automatic logic [7:0] digit_glyph(input logic [3:0] d);
        logic [7:0] seg;
        unique case (d)
            4'd0:    seg = 8'hC0;
            4'd1:    seg = 8'hF9;
            4'd2:    seg = 8'hA4;
            4'd3:    seg = 8'hB0;
            4'd4:    seg = 8'h99;
            4'd5:    seg = 8'h92;
            4'd6:    seg = 8'h82;
            4'd7:    seg = 8'hD8;
            4'd8:    seg = 8'h80;
            4'd9:    seg = 8'h98;
            default: seg = SEG_BLANK;
        endcase
        return seg;
    endfunction

endpackage

// File: hdl/seven_segment_mux_driver.sv
// A request accepted into the first stage register moves on to the result register when
// that is empty or being taken; the result waits there while the output stalls.
// Throughput: one request per cycle while the output does not stall; the first stage
// reduces the counts through byte residue tables, the second splits the residues into
// digits and looks up the glyph. Reset clears the three digit positions and both stage
// valid flags; data registers are not reset.
module seven_segment_mux_driver (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  ssmd_pkg::t_in         i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output ssmd_pkg::t_out        o_out_data
);

    // Digit position per mode.
    logic [1:0] r_pos0, r_pos1, r_pos2;
    logic [1:0] n_pos0, n_pos1, n_pos2;
    logic [1:0] cur_pos;

    // First stage registers.
    logic        r_s1_valid;
    logic [1:0]  r_s1_mode;
    logic [1:0]  r_s1_pos;
    logic [11:0] r_s1_sres;
    logic [9:0]  r_s1_mres;
    logic [11:0] n_s1_sres;
    logic [9:0]  n_s1_mres;

    // Result register.
    logic           r_out_valid;
    ssmd_pkg::t_out r_out_data;
    ssmd_pkg::t_out n_out_data;

    logic accept;
    logic s2_load;

    logic [13:0] s_sum;
    logic [11:0] m_sum;

    assign s2_load    = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || s2_load;
    assign accept     = i_in_valid && o_in_ready;

    // Position selection and advance.
    always_comb begin
        n_pos0  = r_pos0;
        n_pos1  = r_pos1;
        n_pos2  = r_pos2;
        cur_pos = 2'd0;
        unique case (i_in_data.func)
            ssmd_pkg::MODE_MIN_SEC: begin
                cur_pos = r_pos0;
                n_pos0  = r_pos0 + 2'd1;
            end
            ssmd_pkg::MODE_SEC_ANIM: begin
                cur_pos = r_pos1;
                n_pos1  = r_pos1 + 2'd1;
            end
            ssmd_pkg::MODE_MILLI_SEC: begin
                cur_pos = r_pos2;
                n_pos2  = r_pos2 + 2'd1;
            end
            default: begin
                cur_pos = 2'd0;
            end
        endcase
    end

    // Seconds modulo 3600 and milliseconds modulo 1000 from byte residues.
    always_comb begin
        s_sum = 14'(i_in_data.second_count[7:0])
              + 14'(ssmd_pkg::S_TAB1[i_in_data.second_count[15:8]])
              + 14'(ssmd_pkg::S_TAB2[i_in_data.second_count[23:16]])
              + 14'(ssmd_pkg::S_TAB3[i_in_data.second_count[31:24]]);
        if (s_sum >= 14'(3 * ssmd_pkg::SecMod)) begin
            n_s1_sres = 12'(s_sum - 14'(3 * ssmd_pkg::SecMod));
        end else if (s_sum >= 14'(2 * ssmd_pkg::SecMod)) begin
            n_s1_sres = 12'(s_sum - 14'(2 * ssmd_pkg::SecMod));
        end else if (s_sum >= 14'(ssmd_pkg::SecMod)) begin
            n_s1_sres = 12'(s_sum - 14'(ssmd_pkg::SecMod));
        end else begin
            n_s1_sres = 12'(s_sum);
        end

        m_sum = 12'(i_in_data.milli_count[7:0])
              + 12'(ssmd_pkg::M_TAB1[i_in_data.milli_count[15:8]])
              + 12'(ssmd_pkg::M_TAB2[i_in_data.milli_count[23:16]])
              + 12'(ssmd_pkg::M_TAB3[i_in_data.milli_count[31:24]]);
        if (m_sum >= 12'(3 * ssmd_pkg::MilliMod)) begin
            n_s1_mres = 10'(m_sum - 12'(3 * ssmd_pkg::MilliMod));
        end else if (m_sum >= 12'(2 * ssmd_pkg::MilliMod)) begin
            n_s1_mres = 10'(m_sum - 12'(2 * ssmd_pkg::MilliMod));
        end else if (m_sum >= 12'(ssmd_pkg::MilliMod)) begin
            n_s1_mres = 10'(m_sum - 12'(ssmd_pkg::MilliMod));
        end else begin
            n_s1_mres = 10'(m_sum);
        end
    end

    // Digit extraction from the reduced counts.
    logic [24:0] prod_t;
    logic [24:0] prod_u;
    logic [22:0] prod_h;
    logic [22:0] prod_a;
    logic [22:0] prod_c;
    logic [8:0]  sec_tens_all;   // seconds mod 3600, divided by 10
    logic [5:0]  min_all;        // seconds mod 3600, divided by 60
    logic [2:0]  min_tens;
    logic [3:0]  sec_units;
    logic [2:0]  sec_tens;
    logic [3:0]  min_units;
    logic [6:0]  ms_tens_all;
    logic [3:0]  ms_hundreds;
    logic [3:0]  ms_tens;
    logic [7:0]  seg;

    assign prod_t = 25'(r_s1_sres) * 25'(ssmd_pkg::RECIP_10);
    assign prod_u = 25'(r_s1_sres) * 25'(ssmd_pkg::RECIP_60);
    assign prod_h = 23'(r_s1_sres) * 23'(ssmd_pkg::RECIP_600);
    assign prod_a = 23'(r_s1_mres) * 23'(ssmd_pkg::RECIP_10);
    assign prod_c = 23'(r_s1_mres) * 23'(ssmd_pkg::RECIP_100);

    assign sec_tens_all = prod_t[24:16];
    assign min_all      = prod_u[23:18];
    assign min_tens     = prod_h[22:20];
    assign ms_tens_all  = prod_a[22:16];
    assign ms_hundreds  = prod_c[22:19];

    assign sec_units = 4'(r_s1_sres - 12'(12'(sec_tens_all) * 12'd10));
    assign sec_tens  = 3'(sec_tens_all - 9'(9'(min_all) * 9'd6));
    assign min_units = 4'(min_all - 6'(6'(min_tens) * 6'd10));
    assign ms_tens   = 4'(ms_tens_all - 7'(7'(ms_hundreds) * 7'd10));

    always_comb begin
        seg = ssmd_pkg::SEG_BLANK;
        unique case (r_s1_mode)
            ssmd_pkg::MODE_MIN_SEC: begin
                unique case (r_s1_pos)
                    2'd0: seg = ssmd_pkg::digit_glyph(sec_units);
                    2'd1: seg = ssmd_pkg::digit_glyph({1'b0, sec_tens});
                    2'd2: begin
                        // The minutes-units point blinks on odd seconds.
                        seg = ssmd_pkg::digit_glyph(min_units);
                        if (r_s1_sres[0]) begin
                            seg = seg & ssmd_pkg::SEG_DP_MASK;
                        end
                    end
                    default: seg = ssmd_pkg::digit_glyph({1'b0, min_tens});
                endcase
            end
            ssmd_pkg::MODE_SEC_ANIM: begin
                unique case (r_s1_pos)
                    2'd0:    seg = ssmd_pkg::digit_glyph(sec_units);
                    2'd1:    seg = ssmd_pkg::digit_glyph({1'b0, sec_tens});
                    2'd2:    seg = ssmd_pkg::ANIM_A[r_s1_sres[3:0]];
                    default: seg = ssmd_pkg::ANIM_B[r_s1_sres[3:0]];
                endcase
            end
            ssmd_pkg::MODE_MILLI_SEC: begin
                unique case (r_s1_pos)
                    2'd0:    seg = ssmd_pkg::digit_glyph(ms_tens);
                    2'd1:    seg = ssmd_pkg::digit_glyph(ms_hundreds);
                    2'd2:    seg = ssmd_pkg::digit_glyph(sec_units);
                    default: seg = ssmd_pkg::digit_glyph({1'b0, sec_tens});
                endcase
            end
            default: begin
                seg = ssmd_pkg::SEG_BLANK;
            end
        endcase

        n_out_data.segment_bits = seg;
        // The unused mode blanks the display with no digit enabled.
        if (r_s1_mode == ssmd_pkg::MODE_MIN_SEC || r_s1_mode == ssmd_pkg::MODE_SEC_ANIM ||
            r_s1_mode == ssmd_pkg::MODE_MILLI_SEC) begin
            n_out_data.digit_enable = ssmd_pkg::EN_FIRST >> r_s1_pos;
        end else begin
            n_out_data.digit_enable = ssmd_pkg::EN_NONE;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos0      <= 2'd0;
            r_pos1      <= 2'd0;
            r_pos2      <= 2'd0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_pos0 <= n_pos0;
                r_pos1 <= n_pos1;
                r_pos2 <= n_pos2;
            end
            if (o_in_ready) begin
                r_s1_valid <= i_in_valid;
            end
            if (s2_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Data registers.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_mode <= i_in_data.func;
            r_s1_pos  <= cur_pos;
            r_s1_sres <= n_s1_sres;
            r_s1_mres <= n_s1_mres;
        end
        if (s2_load) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// File: test/seven_segment_mux_driver_tb.sv
module seven_segment_mux_driver_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // The func field also carries an unused selector, which blanks the display.
    localparam logic [1:0] MODE_BLANK = 2'd3;
    localparam int unsigned STALL_LIMIT = 1000;
    localparam int unsigned DRAIN_CYCLES = 6;

    // Glyph tables, index 0 in the lowest byte.
    localparam logic [9:0][7:0] FONT = {
        8'h98, 8'h80, 8'hD8, 8'h82, 8'h92, 8'h99, 8'hB0, 8'hA4, 8'hF9, 8'hC0
    };
    localparam logic [15:0][7:0] SPIN_A = {
        8'hF0, 8'hF4, 8'hF6, 8'hF7, 8'hF7, 8'hF7, 8'hF7, 8'hF7,
        8'hF0, 8'hF8, 8'hF8, 8'hF8, 8'hF8, 8'hF8, 8'hF9, 8'hFB
    };
    localparam logic [15:0][7:0] SPIN_B = {
        8'hC6, 8'hC6, 8'hC6, 8'hC6, 8'hC7, 8'hE7, 8'hF7, 8'hFF,
        8'hC6, 8'hC6, 8'hCE, 8'hDE, 8'hFE, 8'hFF, 8'hFF, 8'hFF
    };

    logic i_clk       = 1'b0;
    logic i_rst_n     = 1'b0;
    logic in_valid    = 1'b0;
    logic out_ready   = 1'b0;
    ssmd_pkg::t_in  in_data = '0;
    logic o_in_ready;
    logic o_out_valid;
    ssmd_pkg::t_out o_out_data;

    logic           sender_idles    = 1'b0;
    logic           receiver_stalls = 1'b0;
    logic [1:0]     digit_pos [3];
    ssmd_pkg::t_out pending_displays [$];
    int unsigned    mismatch_count = 0;
    int unsigned    quiet_cycles   = 0;

    seven_segment_mux_driver u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (o_out_data)
    );

    always #2 i_clk = ~i_clk;

    // Works out the digit shown for one request and steps that mode's position on.
    function automatic ssmd_pkg::t_out advance_display(input ssmd_pkg::t_in req);
        ssmd_pkg::t_out res;
        logic [1:0]     p;
        logic [7:0]     seg;
        int unsigned    s;
        int unsigned    ms;
        s  = req.second_count;
        ms = req.milli_count;
        if (req.func == MODE_BLANK) begin
            res.digit_enable = ssmd_pkg::EN_NONE;
            res.segment_bits = ssmd_pkg::SEG_BLANK;
            return res;
        end
        p = digit_pos[req.func];
        case (req.func)
            ssmd_pkg::MODE_MIN_SEC: begin
                case (p)
                    2'd0: seg = FONT[s % 10];
                    2'd1: seg = FONT[(s / 10) % 6];
                    2'd2: begin
                        seg = FONT[(s / 60) % 10];
                        if (s[0]) seg = seg & ssmd_pkg::SEG_DP_MASK;
                    end
                    default: seg = FONT[(s / 600) % 6];
                endcase
            end
            ssmd_pkg::MODE_SEC_ANIM: begin
                case (p)
                    2'd0:    seg = FONT[s % 10];
                    2'd1:    seg = FONT[(s / 10) % 6];
                    2'd2:    seg = SPIN_A[s[3:0]];
                    default: seg = SPIN_B[s[3:0]];
                endcase
            end
            default: begin
                case (p)
                    2'd0:    seg = FONT[(ms / 10) % 10];
                    2'd1:    seg = FONT[(ms / 100) % 10];
                    2'd2:    seg = FONT[s % 10];
                    default: seg = FONT[(s / 10) % 6];
                endcase
            end
        endcase
        res.digit_enable = ssmd_pkg::EN_FIRST >> p;
        res.segment_bits = seg;
        digit_pos[req.func] = p + 2'd1;
        return res;
    endfunction

    function automatic logic [31:0] random_count();
        case ($urandom_range(3))
            0:       return $urandom();
            1:       return $urandom_range(3599);
            2:       return 32'hFFFF_FFFF - $urandom_range(4000);
            default: return $urandom_range(199999);
        endcase
    endfunction

    // Entered and left just after a falling edge; valid stays high between
    // back-to-back requests unless an idle cycle is drawn.
    task automatic send_request(input logic [1:0] func, input logic [31:0] ms,
                                input logic [31:0] s);
        ssmd_pkg::t_in req;
        req.func         = func;
        req.milli_count  = ms;
        req.second_count = s;
        if (sender_idles && $urandom_range(99) < 16) begin
            in_valid <= 1'b0;
            @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        pending_displays.push_back(advance_display(req));
        @(negedge i_clk);
    endtask

    task automatic test_min_sec_digits();
        // All ones gives an odd second, so the blink lands on the minutes digit.
        repeat (4) send_request(ssmd_pkg::MODE_MIN_SEC, 32'h0, 32'hFFFF_FFFF);
        repeat (4) send_request(ssmd_pkg::MODE_MIN_SEC, 32'hFFFF_FFFF, 32'd3598);
        repeat (4) send_request(ssmd_pkg::MODE_MIN_SEC, 32'h0, 32'h0);
    endtask

    task automatic test_animation_digits();
        repeat (4) send_request(ssmd_pkg::MODE_SEC_ANIM, 32'h0, 32'hFFFF_FFFF);
        repeat (4) send_request(ssmd_pkg::MODE_SEC_ANIM, 32'h0, 32'h0000_0010);
    endtask

    task automatic test_milli_digits();
        repeat (4) send_request(ssmd_pkg::MODE_MILLI_SEC, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    endtask

    task automatic test_blank_selector();
        // The blanked request must leave every position where it was.
        send_request(ssmd_pkg::MODE_MIN_SEC, 32'd123, 32'd61);
        send_request(MODE_BLANK, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(ssmd_pkg::MODE_MIN_SEC, 32'd456, 32'd61);
    endtask

    task automatic test_random_noise(input int unsigned count);
        for (int unsigned i = 0; i < count; i++) begin
            send_request(($urandom_range(9) == 0) ? MODE_BLANK : 2'($urandom_range(2)),
                         random_count(), random_count());
        end
    endtask

    // Ticks of a running stopwatch: counts move forward unless the millisecond count wraps,
    // the mode is held for a while and then changed, much as a refresh loop would drive it.
    task automatic test_running_clock(input int unsigned count);
        logic [31:0] ms;
        logic [1:0]  mode;
        ms   = ($urandom_range(1)) ? random_count() : 32'h0;
        mode = 2'($urandom_range(2));
        for (int unsigned i = 0; i < count; i++) begin
            if ($urandom_range(15) == 0)
                mode = ($urandom_range(19) == 0) ? MODE_BLANK : 2'($urandom_range(2));
            ms = ms + $urandom_range(0, 700);
            send_request(mode, ms, ms / 1000);
        end
    endtask

    always @(negedge i_clk) begin
        out_ready <= !receiver_stalls || ($urandom_range(99) >= 16);
    end

    always @(posedge i_clk) begin
        ssmd_pkg::t_out want;
        if (i_rst_n && o_out_valid && out_ready) begin
            if (pending_displays.size() == 0) begin
                $display("%t: display result %h with none expected", $realtime, o_out_data);
                mismatch_count++;
            end else begin
                want = pending_displays.pop_front();
                if (o_out_data.digit_enable !== want.digit_enable) begin
                    $display("%t: digit_enable expected %h actual %h",
                             $realtime, want.digit_enable, o_out_data.digit_enable);
                    mismatch_count++;
                end
                if (o_out_data.segment_bits !== want.segment_bits) begin
                    $display("%t: segment_bits expected %h actual %h",
                             $realtime, want.segment_bits, o_out_data.segment_bits);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_valid && o_in_ready) || (o_out_valid && out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("seven_segment_mux_driver verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        for (int m = 0; m < 3; m++) digit_pos[m] = 2'd0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_min_sec_digits();
        test_animation_digits();
        test_milli_digits();
        test_blank_selector();

        // A long stretch at full rate, then both sides idle at random.
        test_running_clock(300);
        sender_idles    = 1'b1;
        receiver_stalls = 1'b1;
        test_random_noise(300);
        test_running_clock(550);

        in_valid <= 1'b0;
        while (pending_displays.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && pending_displays.size() == 0) begin
            $display("seven_segment_mux_driver verification clean");
        end else begin
            $display("seven_segment_mux_driver verification failed");
        end
        $finish;
    end

endmodule
